[hdl/ptce_pkg.sv]
// Shared operation codes and sequencer states for the pattern table cursor engine.
package ptce_pkg;

    // Operation codes carried by the kind field.
    localparam logic [4:0] KIND_SEL_RD    = 5'd0;
    localparam logic [4:0] KIND_SEL_WR    = 5'd1;
    localparam logic [4:0] KIND_LEN_RD    = 5'd2;
    localparam logic [4:0] KIND_LEN_WR    = 5'd3;
    localparam logic [4:0] KIND_CUR_RD    = 5'd4;
    localparam logic [4:0] KIND_CUR_WR    = 5'd5;
    localparam logic [4:0] KIND_HERE_RD   = 5'd6;
    localparam logic [4:0] KIND_HERE_WR   = 5'd7;
    localparam logic [4:0] KIND_NEXT_RD   = 5'd8;
    localparam logic [4:0] KIND_NEXT_WR   = 5'd9;
    localparam logic [4:0] KIND_PREV_RD   = 5'd10;
    localparam logic [4:0] KIND_PREV_WR   = 5'd11;
    localparam logic [4:0] KIND_WRAP_RD   = 5'd12;
    localparam logic [4:0] KIND_WRAP_WR   = 5'd13;
    localparam logic [4:0] KIND_START_RD  = 5'd14;
    localparam logic [4:0] KIND_START_WR  = 5'd15;
    localparam logic [4:0] KIND_END_RD    = 5'd16;
    localparam logic [4:0] KIND_END_WR    = 5'd17;
    localparam logic [4:0] KIND_AT_RD     = 5'd18;
    localparam logic [4:0] KIND_AT_WR     = 5'd19;
    localparam logic [4:0] KIND_INSERT    = 5'd20;
    localparam logic [4:0] KIND_DELETE    = 5'd21;
    localparam logic [4:0] KIND_PUSH      = 5'd22;
    localparam logic [4:0] KIND_POP       = 5'd23;
    localparam logic [4:0] KIND_EXP_RD    = 5'd24;
    localparam logic [4:0] KIND_EXP_WR    = 5'd25;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET,
        ST_ENT,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

[hdl/ptce_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module ptce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/pattern_table_cursor_engine_top.sv]
// Top level of the pattern table cursor engine: sequencer around an entry RAM and a setting RAM.
//
// The block holds NUM_PATTERNS patterns of PATTERN_DEPTH signed 16-bit entries, and for each
// pattern a length, a cursor, a start, an end and a wrap flag. One operation beat enters on the
// input channel (in_valid/in_stall) and exactly one result beat leaves on the output channel
// (out_valid/out_stall) carrying has_value and read_value.
//
// After rst_n is released the block sweeps both RAMs to zero, one entry per cycle, over all
// NUM_PATTERNS*PATTERN_DEPTH entry slots (256 with the defaults); in_stall stays high meanwhile.
//
// One beat is handled at a time. Setting accesses and entry writes pass through ST_SET and
// ST_DONE; entry reads and a pop that returns an entry also pass through ST_ENT, since the
// entry RAM has a registered read port. Insert and delete move one entry per cycle through
// the RAM's read and write ports in ST_SHIFT, at most PATTERN_DEPTH-1 entries. The next beat
// is accepted on the cycle after the result is registered.
//
// The result sits in an output register. If the receiver stalls, the register holds its beat
// and the finished item waits in its last state until the register frees up.
module pattern_table_cursor_engine_top #(
    parameter int NUM_PATTERNS  = 4,
    parameter int PATTERN_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         kind,
    input  logic signed [15:0] pattern_sel,
    input  logic signed [15:0] position,
    input  logic signed [15:0] operand,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               has_value,
    output logic signed [15:0] read_value
);

    import ptce_pkg::*;

    localparam int NE = NUM_PATTERNS * PATTERN_DEPTH;
    localparam int AW = $clog2(NE);
    localparam int IW = $clog2(PATTERN_DEPTH);
    localparam int PW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int SW = 4 * IW + 1;
    localparam logic [IW-1:0] DMAX = IW'(PATTERN_DEPTH - 1);
    localparam logic [PW-1:0] PMAX = PW'(NUM_PATTERNS - 1);
    localparam logic [AW-1:0] CLR_LAST = AW'(NE - 1);

    // Flat address of entry i of pattern p.
    function automatic logic [AW-1:0] slot(input logic [PW-1:0] p, input logic [IW-1:0] i);
        slot = AW'(AW'(p) * AW'(PATTERN_DEPTH)) + AW'(i);
    endfunction

    // Control registers.
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [PW-1:0]   cur_reg, cur_next;
    logic            out_valid_reg, out_valid_next;
    logic            pend_reg, pend_next;

    // Item and datapath registers.
    logic [4:0]         kind_reg;
    logic signed [15:0] psel_reg, pos_reg, opnd_reg;
    logic [IW-1:0]      ptr_reg, ptr_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      len_reg, len_next;
    logic               del_reg, del_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic               res_has_reg, res_has_next;
    logic [15:0]        res_val_reg, res_val_next;
    logic               has_value_reg;
    logic [15:0]        read_value_reg;
    logic               out_load;

    // RAM ports.
    logic          ent_we;
    logic [AW-1:0] ent_waddr, ent_raddr;
    logic [15:0]   ent_wdata, ent_rdata;
    logic          set_we;
    logic [PW-1:0] set_waddr;
    logic [SW-1:0] set_wdata, set_rdata;

    ptce_ram #(.WIDTH(16), .DEPTH(NE)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    ptce_ram #(.WIDTH(SW), .DEPTH(NUM_PATTERNS)) u_setting_ram (
        .clk   (clk),
        .we    (set_we),
        .waddr (set_waddr),
        .wdata (set_wdata),
        .raddr (cur_reg),
        .rdata (set_rdata)
    );

    // Fields of the setting word of the current pattern, valid in ST_SET.
    logic [IW-1:0] s_len, s_cur, s_start, s_end;
    logic          s_wrap;
    assign {s_wrap, s_end, s_start, s_cur, s_len} = set_rdata;

    // Saturated operands.
    logic [IW-1:0] pos_sat, pos_len, opnd_dmax, opnd_len;
    logic [PW-1:0] psel_sat, opnd_pmax;
    logic          opnd_bit;
    logic [IW-1:0] nxt_cur, prv_cur;
    logic          nxt_edge, prv_edge;

    always_comb
    begin
        pos_sat   = pos_reg[15] ? '0 :
                    ((pos_reg[14:0] > 15'(DMAX)) ? DMAX : pos_reg[IW-1:0]);
        pos_len   = pos_reg[15] ? '0 :
                    ((pos_reg[14:0] > 15'(s_len)) ? s_len : pos_reg[IW-1:0]);
        opnd_dmax = opnd_reg[15] ? '0 :
                    ((opnd_reg[14:0] > 15'(DMAX)) ? DMAX : opnd_reg[IW-1:0]);
        opnd_len  = opnd_reg[15] ? '0 :
                    ((opnd_reg[14:0] > 15'(s_len)) ? s_len : opnd_reg[IW-1:0]);
        psel_sat  = psel_reg[15] ? '0 :
                    ((psel_reg[14:0] > 15'(PMAX)) ? PMAX : psel_reg[PW-1:0]);
        opnd_pmax = opnd_reg[15] ? '0 :
                    ((opnd_reg[14:0] > 15'(PMAX)) ? PMAX : opnd_reg[PW-1:0]);
        opnd_bit  = !opnd_reg[15] && (opnd_reg != '0);

        // Next stops at the last used slot, at the end mark or at the top of the store.
        nxt_edge = ((s_len != '0) && (s_cur == s_len - 1'b1)) || (s_cur == s_end) ||
                   (s_cur >= DMAX);
        nxt_cur  = nxt_edge ? (s_wrap ? s_start : s_cur) : s_cur + 1'b1;
        prv_edge = (s_cur == '0) || (s_cur == s_start);
        prv_cur  = prv_edge ? (s_wrap ? s_end : s_cur) : s_cur - 1'b1;
    end

    // Decode of the item once its settings are read.
    state_t        dec_goto;
    logic          dec_set_we, dec_ent_we;
    logic [SW-1:0] dec_set_word;
    logic [AW-1:0] dec_ent_addr;
    logic          dec_res_has;
    logic [15:0]   dec_res_val;
    logic [PW-1:0] dec_cur;
    logic [IW-1:0] dec_ptr, dec_idx;
    logic          dec_del;

    always_comb
    begin
        logic [IW-1:0] n_len, n_cur, n_start, n_end;
        logic          n_wrap;
        logic          rd;
        logic [IW-1:0] mv;
        n_len   = s_len;
        n_cur   = s_cur;
        n_start = s_start;
        n_end   = s_end;
        n_wrap  = s_wrap;
        rd      = !kind_reg[0];
        mv      = s_cur;

        dec_goto     = ST_DONE;
        dec_set_we   = 1'b0;
        dec_ent_we   = 1'b0;
        dec_ent_addr = slot(cur_reg, pos_sat);
        dec_res_has  = 1'b0;
        dec_res_val  = '0;
        dec_cur      = cur_reg;
        dec_ptr      = s_len;
        dec_idx      = pos_sat;
        dec_del      = 1'b0;

        unique case (kind_reg)
            KIND_SEL_RD:
            begin
                dec_res_has = 1'b1;
                dec_res_val = 16'(cur_reg);
            end
            KIND_SEL_WR:
            begin
                dec_cur = opnd_pmax;
            end
            KIND_LEN_RD:
            begin
                dec_res_has = 1'b1;
                dec_res_val = 16'(s_len);
            end
            KIND_LEN_WR:
            begin
                n_len      = opnd_dmax;
                dec_set_we = 1'b1;
            end
            KIND_CUR_RD:
            begin
                dec_res_has = 1'b1;
                dec_res_val = 16'(s_cur);
            end
            KIND_CUR_WR:
            begin
                n_cur      = opnd_len;
                dec_set_we = 1'b1;
            end
            KIND_WRAP_RD:
            begin
                dec_res_has = 1'b1;
                dec_res_val = 16'(s_wrap);
            end
            KIND_WRAP_WR:
            begin
                n_wrap     = opnd_bit;
                dec_set_we = 1'b1;
            end
            KIND_START_RD:
            begin
                dec_res_has = 1'b1;
                dec_res_val = 16'(s_start);
            end
            KIND_START_WR:
            begin
                n_start    = opnd_dmax;
                dec_set_we = 1'b1;
            end
            KIND_END_RD:
            begin
                dec_res_has = 1'b1;
                dec_res_val = 16'(s_end);
            end
            KIND_END_WR:
            begin
                n_end      = opnd_dmax;
                dec_set_we = 1'b1;
            end
            KIND_HERE_RD, KIND_HERE_WR, KIND_NEXT_RD, KIND_NEXT_WR,
            KIND_PREV_RD, KIND_PREV_WR:
            begin
                if ((kind_reg == KIND_NEXT_RD) || (kind_reg == KIND_NEXT_WR))
                begin
                    mv = nxt_cur;
                end
                else if ((kind_reg == KIND_PREV_RD) || (kind_reg == KIND_PREV_WR))
                begin
                    mv = prv_cur;
                end
                n_cur        = mv;
                dec_set_we   = 1'b1;
                dec_ent_addr = slot(cur_reg, mv);
                dec_res_has  = rd;
                dec_ent_we   = !rd;
                dec_goto     = rd ? ST_ENT : ST_DONE;
            end
            KIND_AT_RD, KIND_AT_WR:
            begin
                dec_res_has = rd;
                dec_ent_we  = !rd;
                dec_goto    = rd ? ST_ENT : ST_DONE;
            end
            KIND_EXP_RD, KIND_EXP_WR:
            begin
                dec_ent_addr = slot(psel_sat, pos_sat);
                dec_res_has  = rd;
                dec_ent_we   = !rd;
                dec_goto     = rd ? ST_ENT : ST_DONE;
            end
            KIND_INSERT:
            begin
                // The shift sequence always ends by writing the operand at the index.
                if (s_len >= pos_sat)
                begin
                    n_len      = (s_len < DMAX) ? s_len + 1'b1 : s_len;
                    dec_set_we = 1'b1;
                end
                dec_goto = ST_SHIFT;
            end
            KIND_DELETE:
            begin
                if (s_len != '0)
                begin
                    n_len      = s_len - 1'b1;
                    dec_set_we = 1'b1;
                    dec_ptr    = pos_len;
                    dec_del    = 1'b1;
                    dec_goto   = ST_SHIFT;
                end
            end
            KIND_PUSH:
            begin
                if (s_len < DMAX)
                begin
                    n_len        = s_len + 1'b1;
                    dec_set_we   = 1'b1;
                    dec_ent_addr = slot(cur_reg, s_len);
                    dec_ent_we   = 1'b1;
                end
            end
            KIND_POP:
            begin
                dec_res_has = 1'b1;
                if (s_len != '0)
                begin
                    n_len        = s_len - 1'b1;
                    dec_set_we   = 1'b1;
                    dec_ent_addr = slot(cur_reg, s_len - 1'b1);
                    dec_goto     = ST_ENT;
                end
            end
            default:
            begin
                dec_goto = ST_DONE;
            end
        endcase

        dec_set_word = {n_wrap, n_end, n_start, n_cur, n_len};
    end

    // One step of the shift sequence: read one entry, write it one slot over next cycle.
    logic          sh_move, sh_final, sh_fin;
    logic [AW-1:0] sh_raddr, sh_waddr;
    logic [IW-1:0] sh_ptr;

    always_comb
    begin
        if (del_reg)
        begin
            sh_move  = ptr_reg < len_reg;
            sh_raddr = slot(cur_reg, ptr_reg + 1'b1);
            sh_ptr   = ptr_reg + 1'b1;
        end
        else
        begin
            sh_move  = ptr_reg > idx_reg;
            sh_raddr = slot(cur_reg, ptr_reg - 1'b1);
            sh_ptr   = ptr_reg - 1'b1;
        end
        sh_waddr = slot(cur_reg, ptr_reg);
        sh_fin   = !sh_move && !pend_reg;
        sh_final = sh_fin && !del_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SET;
                end
            end
            ST_SET:
            begin
                state_next = dec_goto;
            end
            ST_ENT:
            begin
                state_next = ST_DONE;
            end
            ST_SHIFT:
            begin
                if (sh_fin)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: RAM ports and register updates.
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        del_next       = del_reg;
        res_has_next   = res_has_reg;
        res_val_next   = res_val_reg;
        out_load       = 1'b0;

        set_we    = 1'b0;
        set_waddr = cur_reg;
        set_wdata = dec_set_word;
        ent_raddr = dec_ent_addr;

        // A pending shift write owns the write port.
        ent_we    = pend_reg;
        ent_waddr = pend_addr_reg;
        ent_wdata = ent_rdata;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ent_we       = 1'b1;
                ent_waddr    = clr_cnt_reg;
                ent_wdata    = '0;
                set_we       = clr_cnt_reg < AW'(NUM_PATTERNS);
                set_waddr    = clr_cnt_reg[PW-1:0];
                set_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
            end
            ST_SET:
            begin
                set_we       = dec_set_we;
                cur_next     = dec_cur;
                res_has_next = dec_res_has;
                res_val_next = dec_res_val;
                ptr_next     = dec_ptr;
                idx_next     = dec_idx;
                len_next     = s_len;
                del_next     = dec_del;
                if (dec_ent_we)
                begin
                    ent_we    = 1'b1;
                    ent_waddr = dec_ent_addr;
                    ent_wdata = opnd_reg;
                end
            end
            ST_ENT:
            begin
                res_val_next = ent_rdata;
            end
            ST_SHIFT:
            begin
                ent_raddr = sh_raddr;
                if (sh_move)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = sh_waddr;
                    ptr_next       = sh_ptr;
                end
                else if (sh_final)
                begin
                    ent_we    = 1'b1;
                    ent_waddr = slot(cur_reg, idx_reg);
                    ent_wdata = opnd_reg;
                end
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            kind_reg <= kind;
            psel_reg <= pattern_sel;
            pos_reg  <= position;
            opnd_reg <= operand;
        end
        ptr_reg       <= ptr_next;
        idx_reg       <= idx_next;
        len_reg       <= len_next;
        del_reg       <= del_next;
        pend_addr_reg <= pend_addr_next;
        res_has_reg   <= res_has_next;
        res_val_reg   <= res_val_next;
        if (out_load)
        begin
            has_value_reg  <= res_has_reg;
            read_value_reg <= res_has_reg ? res_val_reg : '0;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign has_value  = has_value_reg;
    assign read_value = read_value_reg;

endmodule

[hdl/ptce_checker.sv]
// Port-level checks for the pattern table cursor engine, bound to its top level.
module ptce_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               has_value,
    input logic signed [15:0] read_value
);

    // A stalled result beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(has_value) && $stable(read_value))
        else $error("stalled result beat changed");

    // A result without a value always carries zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_value |-> read_value == 16'sd0)
        else $error("result without value carries nonzero data");

    // Only one item is worked on at a time: an accepted beat closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item is in flight");

    // A new result appears only at the end of an item's work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in flight");

endmodule

bind pattern_table_cursor_engine_top ptce_checker u_ptce_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the pattern table cursor engine: directed table, random beats, scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ptce_pkg::*;

    localparam int NUM_PAT          = 4;
    localparam int DEPTH            = 64;
    localparam int LAST_SLOT        = DEPTH - 1;
    // Sized to outlast the longest item, an insert or delete that shifts a whole pattern.
    localparam int TAIL_CYCLES      = DEPTH + 16;
    localparam int RANDOM_PER_PHASE = 240;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int BURST_BEATS      = 20;
    localparam int N_DIRECTED       = 31;
    localparam int MAX_PRINTED      = 100;

    // Kinds 26..31 carry no operation; the engine must answer them with an empty result.
    localparam logic [4:0] KIND_UNUSED_LO = 5'd26;
    localparam logic [4:0] KIND_UNUSED_HI = 5'd31;

    localparam logic signed [15:0] S16_MIN = 16'sh8000;
    localparam logic signed [15:0] S16_MAX = 16'sh7FFF;

    // Idling mixes, in percent, for the four random phases.
    localparam int SEND_IDLE_MIX [4]  = '{0, 82, 0, 38};
    localparam int RECV_STALL_MIX [4] = '{0, 0, 82, 38};

    localparam logic [4:0] SETTING_KINDS [12] = '{
        KIND_SEL_RD, KIND_SEL_WR, KIND_LEN_RD, KIND_LEN_WR, KIND_CUR_RD, KIND_CUR_WR,
        KIND_WRAP_RD, KIND_WRAP_WR, KIND_START_RD, KIND_START_WR, KIND_END_RD, KIND_END_WR
    };

    typedef struct packed {
        logic        has;
        logic [15:0] val;
    } result_t;

    typedef struct packed {
        logic [4:0]         kind;
        logic signed [15:0] psel;
        logic signed [15:0] pos;
        logic signed [15:0] opnd;
    } op_beat_t;

    // One line of the directed table. When known is set, want is the result typed in by hand.
    typedef struct {
        op_beat_t beat;
        bit       known;
        result_t  want;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [4:0]         kind;
    logic signed [15:0] pattern_sel;
    logic signed [15:0] position;
    logic signed [15:0] operand;
    logic               out_valid;
    logic               out_stall;
    logic               has_value;
    logic signed [15:0] read_value;

    pattern_table_cursor_engine_top #(
        .NUM_PATTERNS  (NUM_PAT),
        .PATTERN_DEPTH (DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .pattern_sel (pattern_sel),
        .position    (position),
        .operand     (operand),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .has_value   (has_value),
        .read_value  (read_value)
    );

    // Shadow copy of the engine's pattern store and per-pattern settings.
    logic [15:0] pat_entry [NUM_PAT][DEPTH] = '{default: '0};
    int unsigned pat_len   [NUM_PAT];
    int unsigned pat_cur   [NUM_PAT];
    int unsigned pat_start [NUM_PAT];
    int unsigned pat_end   [NUM_PAT];
    bit          pat_wrap  [NUM_PAT];
    int unsigned cur_pat;

    // Results still owed by the engine, oldest first.
    result_t pending_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int mismatches;
    int beats_sent;
    int results_seen;
    int value_results;

    // The clock runs free from time zero.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Every mismatch lands here. Printing is capped so that a badly broken build does not
    // flood the log, but every mismatch is counted.
    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function automatic int unsigned clamp_to(input int x, input int unsigned hi);
        if (x < 0)
            return 0;
        if (x > int'(hi))
            return hi;
        return x;
    endfunction

    // Applies one operation to the shadow state and returns the result the engine owes.
    function automatic result_t engine_step(input op_beat_t b);
        result_t     r;
        int unsigned p;
        int unsigned q;
        int unsigned c;
        int unsigned idx;
        int unsigned len;
        r = '0;
        p = cur_pat;
        case (b.kind)
            KIND_SEL_RD:   begin r.has = 1'b1; r.val = 16'(p); end
            KIND_SEL_WR:   cur_pat = clamp_to(b.opnd, NUM_PAT - 1);
            KIND_LEN_RD:   begin r.has = 1'b1; r.val = 16'(pat_len[p]); end
            KIND_LEN_WR:   pat_len[p] = clamp_to(b.opnd, LAST_SLOT);
            KIND_CUR_RD:   begin r.has = 1'b1; r.val = 16'(pat_cur[p]); end
            KIND_CUR_WR:   pat_cur[p] = clamp_to(b.opnd, pat_len[p]);
            KIND_WRAP_RD:  begin r.has = 1'b1; r.val = 16'(pat_wrap[p]); end
            KIND_WRAP_WR:  pat_wrap[p] = clamp_to(b.opnd, 1) != 0;
            KIND_START_RD: begin r.has = 1'b1; r.val = 16'(pat_start[p]); end
            KIND_START_WR: pat_start[p] = clamp_to(b.opnd, LAST_SLOT);
            KIND_END_RD:   begin r.has = 1'b1; r.val = 16'(pat_end[p]); end
            KIND_END_WR:   pat_end[p] = clamp_to(b.opnd, LAST_SLOT);
            KIND_HERE_RD, KIND_HERE_WR, KIND_NEXT_RD, KIND_NEXT_WR, KIND_PREV_RD, KIND_PREV_WR:
            begin
                c = pat_cur[p];
                if (b.kind == KIND_NEXT_RD || b.kind == KIND_NEXT_WR)
                begin
                    // At the last used slot, at the end mark or at the top of the store the
                    // cursor wraps to start, or stays put when wrapping is off.
                    if ((pat_len[p] > 0 && c == pat_len[p] - 1) || c == pat_end[p] ||
                        c >= LAST_SLOT)
                    begin
                        if (pat_wrap[p])
                            pat_cur[p] = pat_start[p];
                    end
                    else
                        pat_cur[p] = c + 1;
                end
                else if (b.kind == KIND_PREV_RD || b.kind == KIND_PREV_WR)
                begin
                    if (c == 0 || c == pat_start[p])
                    begin
                        if (pat_wrap[p])
                            pat_cur[p] = pat_end[p];
                    end
                    else
                        pat_cur[p] = c - 1;
                end
                // Even kinds read, odd kinds write.
                if (b.kind[0] == 1'b0)
                begin
                    r.has = 1'b1;
                    r.val = pat_entry[p][pat_cur[p]];
                end
                else
                    pat_entry[p][pat_cur[p]] = b.opnd;
            end
            KIND_AT_RD:
            begin
                r.has = 1'b1;
                r.val = pat_entry[p][clamp_to(b.pos, LAST_SLOT)];
            end
            KIND_AT_WR:    pat_entry[p][clamp_to(b.pos, LAST_SLOT)] = b.opnd;
            KIND_INSERT:
            begin
                idx = clamp_to(b.pos, LAST_SLOT);
                len = pat_len[p];
                if (len >= idx)
                begin
                    for (int i = len; i > idx; i--)
                        pat_entry[p][i] = pat_entry[p][i - 1];
                    if (len < LAST_SLOT)
                        pat_len[p] = len + 1;
                end
                pat_entry[p][idx] = b.opnd;
            end
            KIND_DELETE:
            begin
                len = pat_len[p];
                idx = clamp_to(b.pos, len);
                if (len > 0)
                begin
                    for (int i = idx; i < len; i++)
                        pat_entry[p][i] = pat_entry[p][i + 1];
                    pat_len[p] = len - 1;
                end
            end
            KIND_PUSH:
            begin
                len = pat_len[p];
                if (len < LAST_SLOT)
                begin
                    pat_entry[p][len] = b.opnd;
                    pat_len[p] = len + 1;
                end
            end
            KIND_POP:
            begin
                r.has = 1'b1;
                if (pat_len[p] > 0)
                begin
                    pat_len[p] = pat_len[p] - 1;
                    r.val = pat_entry[p][pat_len[p]];
                end
            end
            KIND_EXP_RD, KIND_EXP_WR:
            begin
                q = clamp_to(b.psel, NUM_PAT - 1);
                idx = clamp_to(b.pos, LAST_SLOT);
                if (b.kind == KIND_EXP_RD)
                begin
                    r.has = 1'b1;
                    r.val = pat_entry[q][idx];
                end
                else
                    pat_entry[q][idx] = b.opnd;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic directed_row_t dir_row(input logic [4:0] k,
                                              input logic signed [15:0] ps,
                                              input logic signed [15:0] po,
                                              input logic signed [15:0] op,
                                              input bit known,
                                              input logic has,
                                              input logic [15:0] val);
        directed_row_t d;
        d.beat  = '{kind: k, psel: ps, pos: po, opnd: op};
        d.known = known;
        d.want  = '{has: has, val: val};
        return d;
    endfunction

    // Mostly small values around the legal range so that saturation edges are hit often,
    // with full-width and extreme values mixed in.
    function automatic logic signed [15:0] field_value(input int unsigned hi);
        case ($urandom_range(4))
            0: return 16'($urandom);
            1:
                case ($urandom_range(3))
                    0:       return S16_MIN;
                    1:       return S16_MAX;
                    2:       return -16'sd1;
                    default: return '0;
                endcase
            4: return 16'($urandom_range(hi));
            default: return 16'(int'($urandom_range(hi + 2)) - 1);
        endcase
    endfunction

    // Weighted toward push, pop and cursor moves so that patterns fill up, empty out and
    // the cursor runs into its wrap points.
    function automatic op_beat_t random_beat();
        op_beat_t    b;
        int unsigned r;
        int unsigned op_hi;
        r = $urandom_range(99);
        if (r < 3)
            b.kind = 5'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
        else if (r < 18)
            b.kind = KIND_PUSH;
        else if (r < 26)
            b.kind = KIND_POP;
        else if (r < 32)
            b.kind = KIND_INSERT;
        else if (r < 38)
            b.kind = KIND_DELETE;
        else if (r < 50)
            b.kind = $urandom_range(1) ? KIND_NEXT_RD : KIND_NEXT_WR;
        else if (r < 60)
            b.kind = $urandom_range(1) ? KIND_PREV_RD : KIND_PREV_WR;
        else if (r < 66)
            b.kind = $urandom_range(1) ? KIND_HERE_RD : KIND_HERE_WR;
        else if (r < 72)
            b.kind = $urandom_range(1) ? KIND_AT_RD : KIND_AT_WR;
        else if (r < 78)
            b.kind = $urandom_range(1) ? KIND_EXP_RD : KIND_EXP_WR;
        else
            b.kind = SETTING_KINDS[$urandom_range(11)];
        op_hi = (b.kind == KIND_SEL_WR) ? NUM_PAT - 1 :
                (b.kind == KIND_WRAP_WR) ? 1 : LAST_SLOT;
        b.psel = field_value(NUM_PAT - 1);
        b.pos  = field_value(LAST_SLOT);
        b.opnd = field_value(op_hi);
        return b;
    endfunction

    // Offers one beat, holds it until the engine takes it, then records what it owes.
    // The handshake is judged at the falling edge, where every signal is settled for the
    // next rising edge. The task returns just after the accepting rising edge.
    task automatic send_beat(input op_beat_t b, input bit known, input result_t typed);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= b.kind;
        pattern_sel <= b.psel;
        position    <= b.pos;
        operand     <= b.opnd;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
            @(posedge clk);
        end
        predicted = engine_step(b);
        pending_results.push_back(known ? typed : predicted);
        beats_sent++;
        @(posedge clk);
    endtask

    // Sender pause until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Main sequence. The directed table walks every operation at least once, with the extremes of
    // each field and the special cases: reads after reset, pop on an empty pattern, push
    // into a full pattern, insert at index zero into a full pattern, delete with an index
    // past the length, cursor and setting saturation, next and prev wrapping at the top of
    // the store and at the start mark, and the unused kinds. Rows whose result is plain
    // from the row above carry it typed in; the others are checked against the predictor.
    // Four random phases follow, one per idling mix, each ending with a full drain.
    initial
    begin : stimulus
        directed_row_t rows [N_DIRECTED];

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = '0;
        pattern_sel    = '0;
        position       = '0;
        operand        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;

        rows = '{
            // Everything reads zero out of reset, and popping an empty pattern gives zero.
            dir_row(KIND_SEL_RD,    '0,      '0,      '0,       1, 1'b1, 16'd0),
            dir_row(KIND_POP,       '0,      '0,      '0,       1, 1'b1, 16'd0),
            dir_row(KIND_HERE_RD,   '0,      '0,      '0,       1, 1'b1, 16'd0),
            // Select saturates to the last pattern.
            dir_row(KIND_SEL_WR,    '0,      '0,      S16_MAX,  1, 1'b0, 16'd0),
            dir_row(KIND_SEL_RD,    '0,      '0,      '0,       1, 1'b1, 16'd3),
            // Length saturates to 63; a push into the full pattern is dropped.
            dir_row(KIND_LEN_WR,    '0,      '0,      S16_MAX,  1, 1'b0, 16'd0),
            dir_row(KIND_LEN_RD,    '0,      '0,      '0,       1, 1'b1, 16'd63),
            dir_row(KIND_PUSH,      '0,      '0,      16'sd1234, 1, 1'b0, 16'd0),
            dir_row(KIND_LEN_RD,    '0,      '0,      '0,       1, 1'b1, 16'd63),
            // Insert at the bottom of a full pattern shifts everything but keeps the length;
            // delete with a huge index clamps to the length and just shortens the pattern.
            dir_row(KIND_INSERT,    '0,      S16_MIN, S16_MIN,  1, 1'b0, 16'd0),
            dir_row(KIND_DELETE,    '0,      S16_MAX, '0,       1, 1'b0, 16'd0),
            dir_row(KIND_AT_RD,     '0,      -16'sd1, '0,       1, 1'b1, 16'h8000),
            dir_row(KIND_AT_WR,     '0,      S16_MAX, S16_MAX,  1, 1'b0, 16'd0),
            dir_row(KIND_EXP_RD,    S16_MAX, S16_MAX, '0,       1, 1'b1, 16'h7FFF),
            dir_row(KIND_EXP_WR,    S16_MIN, S16_MIN, -16'sd1,  1, 1'b0, 16'd0),
            // Wrap, start and end saturate at both sides.
            dir_row(KIND_WRAP_WR,   '0,      '0,      S16_MAX,  1, 1'b0, 16'd0),
            dir_row(KIND_WRAP_RD,   '0,      '0,      '0,       1, 1'b1, 16'd1),
            dir_row(KIND_START_WR,  '0,      '0,      S16_MAX,  1, 1'b0, 16'd0),
            dir_row(KIND_START_RD,  '0,      '0,      '0,       1, 1'b1, 16'd63),
            dir_row(KIND_END_WR,    '0,      '0,      S16_MIN,  1, 1'b0, 16'd0),
            dir_row(KIND_END_RD,    '0,      '0,      '0,       1, 1'b1, 16'd0),
            // The cursor clamps to the length, here 62.
            dir_row(KIND_CUR_WR,    '0,      '0,      S16_MAX,  1, 1'b0, 16'd0),
            dir_row(KIND_CUR_RD,    '0,      '0,      '0,       1, 1'b1, 16'd62),
            // Step up to the top slot, wrap to start, then wrap back down to end.
            dir_row(KIND_NEXT_RD,   '0,      '0,      '0,       0, 1'b0, 16'd0),
            dir_row(KIND_NEXT_WR,   '0,      '0,      16'sh5A5A, 0, 1'b0, 16'd0),
            dir_row(KIND_PREV_RD,   '0,      '0,      '0,       0, 1'b0, 16'd0),
            dir_row(KIND_PREV_WR,   '0,      '0,      16'sh0F0F, 0, 1'b0, 16'd0),
            dir_row(KIND_HERE_WR,   '0,      '0,      16'sh2222, 0, 1'b0, 16'd0),
            // Back to pattern 0, whose first entry was written through the explicit path.
            dir_row(KIND_SEL_WR,    '0,      '0,      S16_MIN,  1, 1'b0, 16'd0),
            dir_row(KIND_EXP_RD,    S16_MIN, S16_MIN, '0,       1, 1'b1, 16'hFFFF),
            dir_row(KIND_UNUSED_HI, -16'sd1, -16'sd1, -16'sd1,  1, 1'b0, 16'd0)
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The engine clears its store after reset with in_stall high; the first beat
        // simply waits for it.
        foreach (rows[i])
            send_beat(rows[i].beat, rows[i].known, rows[i].want);
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = SEND_IDLE_MIX[ph];
            recv_stall_pct = RECV_STALL_MIX[ph];
            repeat (RANDOM_PER_PHASE)
                send_beat(random_beat(), 1'b0, '0);
            if (ph == 1)
            begin
                // The receiver holds off for a long stretch while beats keep coming, so the
                // output register fills and the engine has to stall its input.
                hold_request  = HOLD_OFF_CYCLES;
                send_idle_pct = 0;
                repeat (BURST_BEATS)
                    send_beat(random_beat(), 1'b0, '0);
            end
            drain_results();
        end

        // Give a stray extra result time to show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d beats: %0d from the directed table, the rest random over four",
                 beats_sent, N_DIRECTED);
        $display("idle/stall mixes and a %0d-cycle output hold-off; %0d results, %0d with a value.",
                 HOLD_OFF_CYCLES, results_seen, value_results);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver side. A hold-off request from the main sequence is counted down here, cycle
    // by cycle; otherwise the stall is drawn at the current stalling rate.
    initial
    begin : receiver
        int hold_left;
        out_stall = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Scoreboard. A result beat is taken at the next rising edge whenever out_valid is high
    // and out_stall low at the falling edge, since neither changes in between.
    always @(negedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (has_value)
                value_results++;
            if (pending_results.size() == 0)
                flag_mismatch($sformatf("result %0d with nothing owed: has_value=%0b value=%04h",
                                        results_seen, has_value, read_value));
            else
            begin
                want = pending_results.pop_front();
                if (has_value !== want.has)
                    flag_mismatch($sformatf("result %0d: has_value=%0b, expected %0b",
                                            results_seen, has_value, want.has));
                if (read_value !== want.val)
                    flag_mismatch($sformatf("result %0d: read_value=%04h, expected %04h",
                                            results_seen, read_value, want.val));
            end
        end
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin : watchdog
        #(5_000_000);
        $display("Timeout with %0d results still owed.", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

[pattern_table_cursor_engine_top.f]
hdl/ptce_pkg.sv
hdl/ptce_ram.sv
hdl/pattern_table_cursor_engine_top.sv
hdl/ptce_checker.sv
tb/testbench.sv
